[design/pso_pkg.sv]
// Shared codes and types for the planar shape overlap test.
package pso_pkg;

  // Pair type codes
  localparam logic [1:0] FUNC_CIRC_CIRC = 2'd0;
  localparam logic [1:0] FUNC_TRI_TRI   = 2'd1;
  localparam logic [1:0] FUNC_CIRC_TRI  = 2'd2;
  localparam logic [1:0] FUNC_TRI_CIRC  = 2'd3;

  // Load enables of the four pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

[design/pso_shape_if.sv]
// Handshake channels: shape pair input and overlap result output.
interface pso_shape_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] a_vertex_one;
  logic [31:0] a_vertex_two;
  logic [31:0] a_vertex_three;
  logic [15:0] a_radius;
  logic [31:0] b_vertex_one;
  logic [31:0] b_vertex_two;
  logic [31:0] b_vertex_three;
  logic [15:0] b_radius;

  modport source (output valid, func, a_vertex_one, a_vertex_two, a_vertex_three, a_radius,
                  b_vertex_one, b_vertex_two, b_vertex_three, b_radius, input ready);
  modport sink (input valid, func, a_vertex_one, a_vertex_two, a_vertex_three, a_radius,
                b_vertex_one, b_vertex_two, b_vertex_three, b_radius, output ready);
endinterface

interface pso_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

[design/planar_shape_overlap_test.sv]
// Top level: shape pair overlap test, four-stage pipeline with handshake control.
// An accepted pair passes the stage 1, 2, 3 and 4 registers; result.valid is the stage 4 valid bit.
// Throughput: one transaction per cycle when not stalled by result.ready; each stage
// holds one item and moves when the stage after it is empty or moving, so stalls lose nothing.
// Reset clears the four stage valid bits; data registers are not reset.
module planar_shape_overlap_test import pso_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input logic           clk,
  input logic           rst,
  pso_shape_if.sink     shapes,
  pso_result_if.source  result
);

  localparam int XW = 2 * (COORD_BITS + 1) + 1;

  logic [4:1] v;
  logic [4:1] rdy;
  stage_en_t  en;

  // Per-stage ready chain
  assign rdy[4] = !v[4] || result.ready;
  assign rdy[3] = !v[3] || rdy[4];
  assign rdy[2] = !v[2] || rdy[3];
  assign rdy[1] = !v[1] || rdy[2];
  assign en     = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4]};

  assign shapes.ready = rdy[1];
  assign result.valid = v[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= shapes.valid;
      if (rdy[2]) v[2] <= v[1];
      if (rdy[3]) v[3] <= v[2];
      if (rdy[4]) v[4] <= v[3];
    end
  end

  logic [1:0]           func2;
  logic signed [XW-1:0] pit_c [7][3];
  logic signed [XW-1:0] seg_d [9];
  logic signed [XW-1:0] seg_t [9];
  logic signed [XW-1:0] seg_u [9];
  logic signed [XW-1:0] e_len [3];
  logic signed [XW-1:0] e_dot [3];
  logic signed [XW-1:0] e_cr [3];
  logic signed [XW-1:0] e_da [3];
  logic signed [XW-1:0] e_db [3];
  logic signed [XW-1:0] cc_dsq;
  logic [31:0]          rsq;
  logic [33:0]          rs2;

  pso_front #(.C(COORD_BITS)) u_front (
    .clk     (clk),
    .en      (en),
    .func_in (shapes.func),
    .a_vert  ({shapes.a_vertex_three, shapes.a_vertex_two, shapes.a_vertex_one}),
    .b_vert  ({shapes.b_vertex_three, shapes.b_vertex_two, shapes.b_vertex_one}),
    .a_rad   (shapes.a_radius),
    .b_rad   (shapes.b_radius),
    .func2   (func2),
    .pit_c   (pit_c),
    .seg_d   (seg_d),
    .seg_t   (seg_t),
    .seg_u   (seg_u),
    .e_len   (e_len),
    .e_dot   (e_dot),
    .e_cr    (e_cr),
    .e_da    (e_da),
    .e_db    (e_db),
    .cc_dsq  (cc_dsq),
    .rsq     (rsq),
    .rs2     (rs2)
  );

  pso_back #(.C(COORD_BITS)) u_back (
    .clk    (clk),
    .en     (en),
    .func2  (func2),
    .pit_c  (pit_c),
    .seg_d  (seg_d),
    .seg_t  (seg_t),
    .seg_u  (seg_u),
    .e_len  (e_len),
    .e_dot  (e_dot),
    .e_cr   (e_cr),
    .e_da   (e_da),
    .e_db   (e_db),
    .cc_dsq (cc_dsq),
    .rsq    (rsq),
    .rs2    (rs2),
    .hit    (result.hit)
  );

`ifndef NO_ASSERTIONS
  // an accepted transaction lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (shapes.valid && shapes.ready) |=> v[1])
    else $error("accepted transaction missing from stage 1");

  // input backpressure only when every stage holds an item
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !rdy[1] |-> (v[1] && v[2] && v[3] && v[4]))
    else $error("input stalled with an empty stage");

  // a stalled stage 3 keeps its item
  a_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (v[3] && !rdy[3]) |=> v[3])
    else $error("stalled stage 3 item lost");
`endif

endmodule

[design/pso_front.sv]
// Stages 1 and 2: unpack vertices, then all cross, dot and squared terms.
module pso_front import pso_pkg::*; #(
  parameter int C = 16,
  localparam int DW = C + 1,
  localparam int PW = 2 * DW,
  localparam int XW = PW + 1
) (
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic [1:0]           func_in,
  input  logic [2:0][31:0]     a_vert,
  input  logic [2:0][31:0]     b_vert,
  input  logic [15:0]          a_rad,
  input  logic [15:0]          b_rad,
  output logic [1:0]           func2,
  output logic signed [XW-1:0] pit_c [7][3],
  output logic signed [XW-1:0] seg_d [9],
  output logic signed [XW-1:0] seg_t [9],
  output logic signed [XW-1:0] seg_u [9],
  output logic signed [XW-1:0] e_len [3],
  output logic signed [XW-1:0] e_dot [3],
  output logic signed [XW-1:0] e_cr [3],
  output logic signed [XW-1:0] e_da [3],
  output logic signed [XW-1:0] e_db [3],
  output logic signed [XW-1:0] cc_dsq,
  output logic [31:0]          rsq,
  output logic [33:0]          rs2
);

  function automatic logic signed [DW-1:0] sub(input logic signed [C-1:0] a,
                                                input logic signed [C-1:0] b);
    sub = DW'(a) - DW'(b);
  endfunction

  function automatic logic signed [XW-1:0] cr2(input logic signed [DW-1:0] ux,
                                                input logic signed [DW-1:0] uy,
                                                input logic signed [DW-1:0] vx,
                                                input logic signed [DW-1:0] vy);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    p = ux * vy;
    q = uy * vx;
    cr2 = XW'(p) - XW'(q);
  endfunction

  function automatic logic signed [XW-1:0] dot2(input logic signed [DW-1:0] ux,
                                                 input logic signed [DW-1:0] uy,
                                                 input logic signed [DW-1:0] vx,
                                                 input logic signed [DW-1:0] vy);
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] q;
    p = ux * vx;
    q = uy * vy;
    dot2 = XW'(p) + XW'(q);
  endfunction

  // Stage 1 registers: unpacked points, circle/triangle selection
  logic [1:0]          func1;
  logic signed [C-1:0] ax [3];
  logic signed [C-1:0] ay [3];
  logic signed [C-1:0] bx [3];
  logic signed [C-1:0] by [3];
  logic signed [C-1:0] tx [3];
  logic signed [C-1:0] ty [3];
  logic signed [C-1:0] cx;
  logic signed [C-1:0] cy;
  logic [15:0]         r1;
  logic [16:0]         rs1;

  logic [63:0] aw [3];
  logic [63:0] bw [3];
  logic        circ_b;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      aw[i] = 64'(a_vert[i]);
      bw[i] = 64'(b_vert[i]);
    end
    circ_b = (func_in == FUNC_TRI_CIRC);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      func1 <= func_in;
      for (int i = 0; i < 3; i++) begin
        ax[i] <= aw[i][2*C-1:C];
        ay[i] <= aw[i][C-1:0];
        bx[i] <= bw[i][2*C-1:C];
        by[i] <= bw[i][C-1:0];
        tx[i] <= circ_b ? aw[i][2*C-1:C] : bw[i][2*C-1:C];
        ty[i] <= circ_b ? aw[i][C-1:0] : bw[i][C-1:0];
      end
      cx  <= circ_b ? bw[0][2*C-1:C] : aw[0][2*C-1:C];
      cy  <= circ_b ? bw[0][C-1:0] : aw[0][C-1:0];
      r1  <= circ_b ? b_rad : a_rad;
      rs1 <= 17'(a_rad) + 17'(b_rad);
    end
  end

  // Stage 2 arithmetic
  logic signed [XW-1:0] pit_w [7][3];
  logic signed [XW-1:0] sd_w [9];
  logic signed [XW-1:0] st_w [9];
  logic signed [XW-1:0] su_w [9];
  logic signed [XW-1:0] len_w [3];
  logic signed [XW-1:0] dot_w [3];
  logic signed [XW-1:0] cr_w [3];
  logic signed [XW-1:0] da_w [3];
  logic signed [XW-1:0] db_w [3];
  logic signed [DW-1:0] ccx;
  logic signed [DW-1:0] ccy;

  genvar k, j;
  generate
    for (k = 0; k < 3; k++) begin : g_tri
      localparam int K1 = (k + 1) % 3;
      // point-in-triangle edge crosses: cross3(v1,v2,p) = (v2-v1) x (p-v1)
      for (j = 0; j < 3; j++) begin : g_pit
        localparam int J1 = (j + 1) % 3;
        assign pit_w[k][j] = cr2(sub(bx[J1], bx[j]), sub(by[J1], by[j]),
                                 sub(ax[k], bx[j]), sub(ay[k], by[j]));
        assign pit_w[k+3][j] = cr2(sub(ax[J1], ax[j]), sub(ay[J1], ay[j]),
                                   sub(bx[k], ax[j]), sub(by[k], ay[j]));
        // edge pair: A edge k against B edge j
        assign sd_w[k*3+j] = cr2(sub(ax[K1], ax[k]), sub(ay[K1], ay[k]),
                                 sub(bx[J1], bx[j]), sub(by[J1], by[j]));
        assign st_w[k*3+j] = cr2(sub(bx[j], ax[k]), sub(by[j], ay[k]),
                                 sub(bx[J1], bx[j]), sub(by[J1], by[j]));
        assign su_w[k*3+j] = cr2(sub(bx[j], ax[k]), sub(by[j], ay[k]),
                                 sub(ax[K1], ax[k]), sub(ay[K1], ay[k]));
      end
      assign pit_w[6][k] = cr2(sub(tx[K1], tx[k]), sub(ty[K1], ty[k]),
                               sub(cx, tx[k]), sub(cy, ty[k]));
      // circle center against triangle edge k
      assign len_w[k] = dot2(sub(tx[K1], tx[k]), sub(ty[K1], ty[k]),
                             sub(tx[K1], tx[k]), sub(ty[K1], ty[k]));
      assign dot_w[k] = dot2(sub(cx, tx[k]), sub(cy, ty[k]),
                             sub(tx[K1], tx[k]), sub(ty[K1], ty[k]));
      assign cr_w[k]  = cr2(sub(tx[K1], tx[k]), sub(ty[K1], ty[k]),
                            sub(cx, tx[k]), sub(cy, ty[k]));
      assign da_w[k]  = dot2(sub(cx, tx[k]), sub(cy, ty[k]),
                             sub(cx, tx[k]), sub(cy, ty[k]));
      assign db_w[k]  = dot2(sub(cx, tx[K1]), sub(cy, ty[K1]),
                             sub(cx, tx[K1]), sub(cy, ty[K1]));
    end
  endgenerate

  assign ccx = sub(ax[0], bx[0]);
  assign ccy = sub(ay[0], by[0]);

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (en.s2) begin
      func2 <= func1;
      for (int i = 0; i < 7; i++) begin
        for (int m = 0; m < 3; m++) begin
          pit_c[i][m] <= pit_w[i][m];
        end
      end
      for (int i = 0; i < 9; i++) begin
        seg_d[i] <= sd_w[i];
        seg_t[i] <= st_w[i];
        seg_u[i] <= su_w[i];
      end
      for (int i = 0; i < 3; i++) begin
        e_len[i] <= len_w[i];
        e_dot[i] <= dot_w[i];
        e_cr[i]  <= cr_w[i];
        e_da[i]  <= da_w[i];
        e_db[i]  <= db_w[i];
      end
      cc_dsq <= dot2(ccx, ccy, ccx, ccy);
      rsq    <= 32'(r1) * 32'(r1);
      rs2    <= 34'(rs1) * 34'(rs1);
    end
  end

endmodule

[design/pso_back.sv]
// Stages 3 and 4: sign tests, edge distance products and final decision.
module pso_back import pso_pkg::*; #(
  parameter int C = 16,
  localparam int XW = 2 * (C + 1) + 1,
  localparam int MG = XW - 1,
  localparam int UW = XW + 32,
  localparam int MW = 2 * MG + 32
) (
  input  logic                 clk,
  input  stage_en_t            en,
  input  logic [1:0]           func2,
  input  logic signed [XW-1:0] pit_c [7][3],
  input  logic signed [XW-1:0] seg_d [9],
  input  logic signed [XW-1:0] seg_t [9],
  input  logic signed [XW-1:0] seg_u [9],
  input  logic signed [XW-1:0] e_len [3],
  input  logic signed [XW-1:0] e_dot [3],
  input  logic signed [XW-1:0] e_cr [3],
  input  logic signed [XW-1:0] e_da [3],
  input  logic signed [XW-1:0] e_db [3],
  input  logic signed [XW-1:0] cc_dsq,
  input  logic [31:0]          rsq,
  input  logic [33:0]          rs2,
  output logic                 hit
);

  // Stage 3 combinational decisions
  logic [6:0]        pit_w;
  logic [8:0]        seg_w;
  logic [2:0]        simple_w;
  logic [2:0]        mid_w;
  logic [MW-1:0]     msq_w [3];
  logic [MW-1:0]     rl_w [3];
  logic              cc_w;
  logic [MG-1:0]     mag;
  logic [2*MG-1:0]   sq;
  logic [MG+31:0]    rl;
  logic              near;

  always_comb begin
    mag  = '0;
    sq   = '0;
    rl   = '0;
    near = 1'b0;
    for (int i = 0; i < 7; i++) begin
      pit_w[i] = (pit_c[i][0] >= 0 && pit_c[i][1] >= 0 && pit_c[i][2] >= 0) ||
                 (pit_c[i][0] <= 0 && pit_c[i][1] <= 0 && pit_c[i][2] <= 0);
    end
    // parallel edges never cross
    for (int i = 0; i < 9; i++) begin
      if (seg_d[i] > 0) begin
        seg_w[i] = seg_t[i] >= 0 && seg_t[i] <= seg_d[i] &&
                   seg_u[i] >= 0 && seg_u[i] <= seg_d[i];
      end else if (seg_d[i] < 0) begin
        seg_w[i] = seg_t[i] <= 0 && seg_t[i] >= seg_d[i] &&
                   seg_u[i] <= 0 && seg_u[i] >= seg_d[i];
      end else begin
        seg_w[i] = 1'b0;
      end
    end
    // closest point clamped to the edge; zero-length edge falls to its start
    for (int i = 0; i < 3; i++) begin
      near        = (e_len[i] == 0) || (e_dot[i] <= 0);
      mid_w[i]    = !near && !(e_dot[i] >= e_len[i]);
      simple_w[i] = near ? (UW'(e_da[i][XW-2:0]) <= UW'(rsq))
                         : (UW'(e_db[i][XW-2:0]) <= UW'(rsq));
      mag         = e_cr[i] < 0 ? MG'(-e_cr[i]) : MG'(e_cr[i]);
      sq          = (2*MG)'(mag) * (2*MG)'(mag);
      rl          = (MG+32)'(rsq) * (MG+32)'(e_len[i][MG-1:0]);
      msq_w[i]    = MW'(sq);
      rl_w[i]     = MW'(rl);
    end
    cc_w = UW'(cc_dsq[XW-2:0]) <= UW'(rs2);
  end

  // Stage 3 registers
  logic [1:0]    func3;
  logic [6:0]    pit3;
  logic [8:0]    seg3;
  logic [2:0]    simple3;
  logic [2:0]    mid3;
  logic [MW-1:0] msq3 [3];
  logic [MW-1:0] rl3 [3];
  logic          cc3;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      func3   <= func2;
      pit3    <= pit_w;
      seg3    <= seg_w;
      simple3 <= simple_w;
      mid3    <= mid_w;
      cc3     <= cc_w;
      for (int i = 0; i < 3; i++) begin
        msq3[i] <= msq_w[i];
        rl3[i]  <= rl_w[i];
      end
    end
  end

  // Stage 4: wide compare and selection by pair type
  logic [2:0] edge_hit;
  logic       hit_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      edge_hit[i] = mid3[i] ? (msq3[i] <= rl3[i]) : simple3[i];
    end
    case (func3)
      FUNC_CIRC_CIRC: hit_next = cc3;
      FUNC_TRI_TRI:   hit_next = (|pit3[5:0]) || (|seg3);
      default:        hit_next = pit3[6] || (|edge_hit);
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s4) begin
      hit <= hit_next;
    end
  end

endmodule
